@@ sv/hrpd_pkg.sv @@
// Shared widths, constants and types of the HSV to RGB PWM duty block.
`timescale 1ns / 1ps

package hrpd_pkg;

	localparam int HUE_W = 9;
	localparam int PCT_W = 8;
	localparam int CL_W = 7;
	localparam int WF_W = 6;
	localparam int VS_W = 14;
	localparam int UNIT_W = 20;
	localparam int SCL_W = 24;
	localparam int LVL_W = 8;
	localparam int PER_W = 16;
	localparam int CMP_W = 16;
	localparam int LP_W = LVL_W + PER_W;
	localparam int RCP_W = 25;
	localparam int MUL_W = 49;
	localparam int ADDR_W = 2;
	localparam int DATA_W = 32;

	localparam logic [HUE_W-1:0] HUE_WRAP = HUE_W'(360);
	localparam logic [CL_W-1:0] PCT_MAX = CL_W'(100);
	localparam logic [SCL_W-1:0] UNIT_GAIN = SCL_W'(17);
	localparam logic [RCP_W-1:0] LVL_RECIP = RCP_W'(27487791);
	localparam int LVL_SHIFT = 40;
	localparam logic [RCP_W-1:0] CMP_RECIP = RCP_W'(16843010);
	localparam int CMP_SHIFT = 32;
	localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(10000);
	localparam logic [ADDR_W-1:0] ADDR_PWM_PERIOD = ADDR_W'(0);

	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYN,
		SEC_CYN_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} sector_t;

	typedef struct packed {
		logic valid;
		logic [LVL_W-1:0] red;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] blue;
	} levels_t;

endpackage

@@ sv/hrpd_in_if.sv @@
// Color input channel: hue, saturation and value with a valid/ready handshake.
`timescale 1ns / 1ps

interface hrpd_in_if;
	import hrpd_pkg::*;

	logic valid;
	logic ready;
	logic [HUE_W-1:0] hue_deg;
	logic [PCT_W-1:0] saturation_pct;
	logic [PCT_W-1:0] value_pct;

	modport source(output valid, output hue_deg, output saturation_pct, output value_pct,
		input ready);
	modport sink(input valid, input hue_deg, input saturation_pct, input value_pct,
		output ready);
endinterface

@@ sv/hrpd_out_if.sv @@
// Result channel: RGB levels and PWM compare values with a valid/ready handshake.
`timescale 1ns / 1ps

interface hrpd_out_if;
	import hrpd_pkg::*;

	logic valid;
	logic ready;
	logic [LVL_W-1:0] red_level;
	logic [LVL_W-1:0] green_level;
	logic [LVL_W-1:0] blue_level;
	logic [CMP_W-1:0] red_compare;
	logic [CMP_W-1:0] green_compare;
	logic [CMP_W-1:0] blue_compare;

	modport source(output valid, output red_level, output green_level, output blue_level,
		output red_compare, output green_compare, output blue_compare, input ready);
	modport sink(input valid, input red_level, input green_level, input blue_level,
		input red_compare, input green_compare, input blue_compare, output ready);
endinterface

@@ sv/hsv_to_rgb_pwm_duty.sv @@
// Top level of the HSV to RGB converter with PWM compare outputs.
`timescale 1ns / 1ps

// Converts one color beat (hue in degrees, saturation and value in percent) into
// 8-bit red, green and blue levels and three PWM compare values level*period/255,
// all with exact integer truncation. Hue of 360 or more is taken as 0 and the
// percentages are clamped to 100. The block is a seven-stage pipeline that takes
// one beat per clock while the output is not stalled; each stage holds its beat
// while the stage after it is full, and bubbles close up under back pressure. The
// PWM period is an APB register at address 0 (reset 10000) and should be changed
// only while the pipeline is empty.
module hsv_to_rgb_pwm_duty (
	input  logic clk,
	input  logic arst_n,
	hrpd_in_if.sink color,
	hrpd_out_if.source duty,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [hrpd_pkg::ADDR_W-1:0] paddr,
	input  logic [hrpd_pkg::DATA_W-1:0] pwdata,
	output logic [hrpd_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import hrpd_pkg::*;

	levels_t lv;
	logic pwm_ready;
	logic [PER_W-1:0] pwm_period;

	hrpd_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pwm_period(pwm_period)
	);

	hrpd_color u_color (
		.clk(clk),
		.arst_n(arst_n),
		.color(color),
		.down_ready(pwm_ready),
		.lv(lv)
	);

	hrpd_pwm u_pwm (
		.clk(clk),
		.arst_n(arst_n),
		.lv(lv),
		.pwm_period(pwm_period),
		.up_ready(pwm_ready),
		.duty(duty)
	);

`ifndef SYNTH
	// The input can only be held off when every stage is full and the output is stalled.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!color.ready |-> (lv.valid && !pwm_ready && duty.valid && !duty.ready))
		else $error("input stalled while the pipeline has room");

	// A beat leaving the level stage while the output is free is registered in stage 6
	// and then in stage 7, the output register, after which the output is valid.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		lv.valid && duty.ready |-> ##2 duty.valid)
		else $error("beat lost between level and compare stages");

	// A dark channel always gives a zero compare value.
	a_dark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		duty.valid && (duty.red_level == '0 || duty.green_level == '0
		|| duty.blue_level == '0) |->
		((duty.red_level != '0 || duty.red_compare == '0)
		&& (duty.green_level != '0 || duty.green_compare == '0)
		&& (duty.blue_level != '0 || duty.blue_compare == '0)))
		else $error("nonzero compare value for a dark channel");
`endif
endmodule

@@ sv/hrpd_regs.sv @@
// APB register file holding the PWM period.
`timescale 1ns / 1ps

module hrpd_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [hrpd_pkg::ADDR_W-1:0] paddr,
	input  logic [hrpd_pkg::DATA_W-1:0] pwdata,
	output logic [hrpd_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [hrpd_pkg::PER_W-1:0] pwm_period
);
	import hrpd_pkg::*;

	logic [PER_W-1:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_PWM_PERIOD) begin
			period_q <= pwdata[PER_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PWM_PERIOD) ? DATA_W'(period_q) : '0;
	assign pwm_period = period_q;
endmodule

@@ sv/hrpd_color.sv @@
// Five-stage pipeline from hue, saturation and value to 8-bit RGB levels.
`timescale 1ns / 1ps

module hrpd_color (
	input  logic clk,
	input  logic arst_n,
	hrpd_in_if.sink color,
	input  logic down_ready,
	output hrpd_pkg::levels_t lv
);
	import hrpd_pkg::*;

	logic en1, en2, en3, en4, en5;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;

	// Stage 1: wrap, clamp and sector decode.
	logic [HUE_W-1:0] hue_w;
	logic [CL_W-1:0] hm, hdist;
	sector_t sec;
	sector_t sec_s1, sec_s2, sec_s3;
	logic [WF_W-1:0] wf_s1, wf_s2;
	logic [CL_W-1:0] sat_s1, val_s1;

	// Stage 2.
	logic [VS_W-1:0] vs_s2, v100_s2;

	// Stage 3.
	logic [UNIT_W-1:0] c_s3, x_s3, m_s3;

	// Stage 4.
	logic [UNIT_W-1:0] ch_r, ch_g, ch_b;
	logic [SCL_W-1:0] n_r_s4, n_g_s4, n_b_s4;

	// Stage 5.
	logic [MUL_W-1:0] p_r, p_g, p_b;
	logic [LVL_W-1:0] r_s5, g_s5, b_s5;

	assign en5 = !v5_s5 || down_ready;
	assign en4 = !v4_s4 || en5;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign color.ready = en1;

	always_comb begin
		hue_w = (color.hue_deg >= HUE_WRAP) ? '0 : color.hue_deg;
		priority if (hue_w < HUE_W'(60)) begin
			sec = SEC_RED_YEL;
			hm = hue_w[CL_W-1:0];
		end else if (hue_w < HUE_W'(120)) begin
			sec = SEC_YEL_GRN;
			hm = hue_w[CL_W-1:0];
		end else if (hue_w < HUE_W'(180)) begin
			sec = SEC_GRN_CYN;
			hm = CL_W'(hue_w - HUE_W'(120));
		end else if (hue_w < HUE_W'(240)) begin
			sec = SEC_CYN_BLU;
			hm = CL_W'(hue_w - HUE_W'(120));
		end else if (hue_w < HUE_W'(300)) begin
			sec = SEC_BLU_MAG;
			hm = CL_W'(hue_w - HUE_W'(240));
		end else begin
			sec = SEC_MAG_RED;
			hm = CL_W'(hue_w - HUE_W'(240));
		end
		hdist = (hm >= CL_W'(60)) ? hm - CL_W'(60) : CL_W'(60) - hm;
	end

	always_comb begin
		ch_r = '0;
		ch_g = '0;
		ch_b = '0;
		unique case (sec_s3)
			SEC_RED_YEL: begin
				ch_r = c_s3;
				ch_g = x_s3;
			end
			SEC_YEL_GRN: begin
				ch_r = x_s3;
				ch_g = c_s3;
			end
			SEC_GRN_CYN: begin
				ch_g = c_s3;
				ch_b = x_s3;
			end
			SEC_CYN_BLU: begin
				ch_g = x_s3;
				ch_b = c_s3;
			end
			SEC_BLU_MAG: begin
				ch_r = x_s3;
				ch_b = c_s3;
			end
			default: begin
				ch_r = c_s3;
				ch_b = x_s3;
			end
		endcase
	end

	assign p_r = MUL_W'(n_r_s4) * MUL_W'(LVL_RECIP);
	assign p_g = MUL_W'(n_g_s4) * MUL_W'(LVL_RECIP);
	assign p_b = MUL_W'(n_b_s4) * MUL_W'(LVL_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= color.valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sec_s1 <= sec;
			wf_s1 <= WF_W'(CL_W'(60) - hdist);
			sat_s1 <= (color.saturation_pct > PCT_W'(PCT_MAX)) ? PCT_MAX
				: color.saturation_pct[CL_W-1:0];
			val_s1 <= (color.value_pct > PCT_W'(PCT_MAX)) ? PCT_MAX
				: color.value_pct[CL_W-1:0];
		end
		if (en2) begin
			sec_s2 <= sec_s1;
			wf_s2 <= wf_s1;
			vs_s2 <= VS_W'(val_s1) * VS_W'(sat_s1);
			v100_s2 <= VS_W'(val_s1) * VS_W'(PCT_MAX);
		end
		if (en3) begin
			sec_s3 <= sec_s2;
			c_s3 <= UNIT_W'(vs_s2) * UNIT_W'(60);
			x_s3 <= UNIT_W'(vs_s2) * UNIT_W'(wf_s2);
			m_s3 <= UNIT_W'(v100_s2 - vs_s2) * UNIT_W'(60);
		end
		if (en4) begin
			n_r_s4 <= SCL_W'(ch_r + m_s3) * UNIT_GAIN;
			n_g_s4 <= SCL_W'(ch_g + m_s3) * UNIT_GAIN;
			n_b_s4 <= SCL_W'(ch_b + m_s3) * UNIT_GAIN;
		end
		if (en5) begin
			r_s5 <= LVL_W'(p_r >> LVL_SHIFT);
			g_s5 <= LVL_W'(p_g >> LVL_SHIFT);
			b_s5 <= LVL_W'(p_b >> LVL_SHIFT);
		end
	end

	assign lv.valid = v5_s5;
	assign lv.red = r_s5;
	assign lv.green = g_s5;
	assign lv.blue = b_s5;
endmodule

@@ sv/hrpd_pwm.sv @@
// Two-stage pipeline scaling RGB levels to PWM compare values.
`timescale 1ns / 1ps

module hrpd_pwm (
	input  logic clk,
	input  logic arst_n,
	input  hrpd_pkg::levels_t lv,
	input  logic [hrpd_pkg::PER_W-1:0] pwm_period,
	output logic up_ready,
	hrpd_out_if.source duty
);
	import hrpd_pkg::*;

	logic en6, en7;
	logic v6_s6, v7_s7;
	logic [LVL_W-1:0] r_s6, g_s6, b_s6, r_s7, g_s7, b_s7;
	logic [LP_W-1:0] pr_s6, pg_s6, pb_s6;
	logic [MUL_W-1:0] q_r, q_g, q_b;
	logic [CMP_W-1:0] cr_s7, cg_s7, cb_s7;

	assign en7 = !v7_s7 || duty.ready;
	assign en6 = !v6_s6 || en7;
	assign up_ready = en6;

	assign q_r = MUL_W'(pr_s6) * MUL_W'(CMP_RECIP);
	assign q_g = MUL_W'(pg_s6) * MUL_W'(CMP_RECIP);
	assign q_b = MUL_W'(pb_s6) * MUL_W'(CMP_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v6_s6 <= 1'b0;
			v7_s7 <= 1'b0;
		end else begin
			if (en6) v6_s6 <= lv.valid;
			if (en7) v7_s7 <= v6_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			r_s6 <= lv.red;
			g_s6 <= lv.green;
			b_s6 <= lv.blue;
			pr_s6 <= LP_W'(lv.red) * LP_W'(pwm_period);
			pg_s6 <= LP_W'(lv.green) * LP_W'(pwm_period);
			pb_s6 <= LP_W'(lv.blue) * LP_W'(pwm_period);
		end
		if (en7) begin
			r_s7 <= r_s6;
			g_s7 <= g_s6;
			b_s7 <= b_s6;
			cr_s7 <= CMP_W'(q_r >> CMP_SHIFT);
			cg_s7 <= CMP_W'(q_g >> CMP_SHIFT);
			cb_s7 <= CMP_W'(q_b >> CMP_SHIFT);
		end
	end

	assign duty.valid = v7_s7;
	assign duty.red_level = r_s7;
	assign duty.green_level = g_s7;
	assign duty.blue_level = b_s7;
	assign duty.red_compare = cr_s7;
	assign duty.green_compare = cg_s7;
	assign duty.blue_compare = cb_s7;
endmodule
